// ===== rtl/core/earbm_pkg.sv =====
// Shared constants, types and point-pair tables for the eye aspect ratio block.
`timescale 1ns / 1ps
`default_nettype none
package earbm_pkg;

   localparam int COORD_BITS     = 13;
   localparam int POINTS_PER_EYE = 8;
   localparam int EYE_SLOTS      = 2 * POINTS_PER_EYE;
   localparam int SLOT_W         = $clog2(EYE_SLOTS);
   localparam int PT_W           = $clog2(POINTS_PER_EYE);
   localparam int POINT_W        = 2 * COORD_BITS;

   localparam int IDX_W     = 7;
   localparam int EYE_FIRST = 60;
   localparam int EYE_LAST  = 75;

   localparam int WIN_W     = 7;
   localparam int WIN_RESET = 10;
   localparam int WIN_MAX   = 64;

   localparam int RATIO_W    = 16;
   localparam int RATIO_FRAC = 12;
   localparam int DIST_FRAC  = 4;
   localparam int SUM_W      = 22;

   // magnitude of a coordinate difference, its square sum, the root of the scaled sum
   localparam int MAG_W   = COORD_BITS;
   localparam int SQ_W    = 2 * MAG_W + 1;
   localparam int ROOT_W  = (SQ_W + 2 * DIST_FRAC + 1) / 2;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 2;
   localparam int VSUM_W  = ROOT_W + 2;
   localparam int DIV_W   = ROOT_W + 2;
   localparam int NUM_W   = (SUM_W > RATIO_W) ? SUM_W : RATIO_W;

   localparam int MAX_ITER = (NUM_W > ROOT_W) ? ((NUM_W > MAG_W) ? NUM_W : MAG_W)
                                              : ((ROOT_W > MAG_W) ? ROOT_W : MAG_W);
   localparam int CNT_W    = $clog2(MAX_ITER + 1);

   localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_WINDOW_LEN = '0;

   typedef logic [POINT_W-1:0] point_type;

   // the four distances of one eye, vertical ones first
   typedef enum logic [1:0] {
      DIST_OUTER = 2'd0,
      DIST_INNER = 2'd1,
      DIST_MID   = 2'd2,
      DIST_HORIZ = 2'd3
   } dist_type;

   function automatic logic [PT_W-1:0] point_a(dist_type d);
      logic [PT_W-1:0] p;
      unique case (d)
         DIST_OUTER: p = PT_W'(1);
         DIST_INNER: p = PT_W'(3);
         DIST_MID:   p = PT_W'(2);
         DIST_HORIZ: p = PT_W'(0);
         default:    p = '0;
      endcase
      return p;
   endfunction

   function automatic logic [PT_W-1:0] point_b(dist_type d);
      logic [PT_W-1:0] p;
      unique case (d)
         DIST_OUTER: p = PT_W'(7);
         DIST_INNER: p = PT_W'(5);
         DIST_MID:   p = PT_W'(6);
         DIST_HORIZ: p = PT_W'(4);
         default:    p = '0;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/earbm_if.sv =====
// Valid/ready channel interfaces for landmark points and eye ratio results.
`timescale 1ns / 1ps
`default_nettype none
interface earbm_req_if import earbm_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic [IDX_W-1:0]             landmark_index;

   modport source (output valid, point_x, point_y, landmark_index, input ready);
   modport sink (input valid, point_x, point_y, landmark_index, output ready);
endinterface

interface earbm_rsp_if import earbm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RATIO_W-1:0] ratio_right;
   logic [RATIO_W-1:0] ratio_left;
   logic [RATIO_W-1:0] mean_right;
   logic [RATIO_W-1:0] mean_left;
   logic               mean_updated;
   logic               degenerate_eye;

   modport source (output valid, ratio_right, ratio_left, mean_right, mean_left,
                   mean_updated, degenerate_eye, input ready);
   modport sink (input valid, ratio_right, ratio_left, mean_right, mean_left,
                 mean_updated, degenerate_eye, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/eye_aspect_ratio_block_mean.sv =====
// Eye aspect ratio from stored eye landmarks, with per-eye block means.
// Steps: other landmarks are stored or dropped while idle; the last right-eye point runs
// 8 distances (read pair, difference, shift-add square, square root, accumulate), then per
// eye a ratio check, a divide (skipped when the ratio saturates) and a wrap-up, and on a
// block close a divide of each sum. req.ready stays low until the result is registered; one result is held.
// Reset clears control, sums, count and held means, sets window_len to 10; points are kept.
`timescale 1ns / 1ps
`default_nettype none
module eye_aspect_ratio_block_mean import earbm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   earbm_req_if.sink                  req,
   earbm_rsp_if.source                rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [14:0] {
      S_IDLE        = 15'b000000000000001,
      S_RD_A        = 15'b000000000000010,
      S_RD_B        = 15'b000000000000100,
      S_DIFF        = 15'b000000000001000,
      S_SQUARE      = 15'b000000000010000,
      S_ROOT_LOAD   = 15'b000000000100000,
      S_ROOT        = 15'b000000001000000,
      S_ACCUM       = 15'b000000010000000,
      S_RATIO_CHK   = 15'b000000100000000,
      S_DIV         = 15'b000001000000000,
      S_EYE_DONE    = 15'b000010000000000,
      S_MEAN_ACC    = 15'b000100000000000,
      S_MEAN_R_DONE = 15'b001000000000000,
      S_MEAN_L_DONE = 15'b010000000000000,
      S_EMIT        = 15'b100000000000000
   } state_type;

   // control
   state_type          state_ff, state_in;
   state_type          div_ret_ff, div_ret_in;
   logic               eye_ff, eye_in;
   dist_type           dist_ff, dist_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               degen_ff, degen_in;
   logic               upd_ff, upd_in;
   logic [SUM_W-1:0]   sum_r_ff, sum_r_in;
   logic [SUM_W-1:0]   sum_l_ff, sum_l_in;
   logic [WIN_W-1:0]   count_ff, count_in;
   logic [RATIO_W-1:0] held_r_ff, held_r_in;
   logic [RATIO_W-1:0] held_l_ff, held_l_in;
   logic [WIN_W-1:0]   win_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath
   point_type             mem [EYE_SLOTS];
   point_type             mem_q_ff;
   point_type             pa_ff, pa_in;
   logic [2*MAG_W-1:0]    mcx_ff, mcx_in, mcy_ff, mcy_in;
   logic [MAG_W-1:0]      mpx_ff, mpx_in, mpy_ff, mpy_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [REM_W-1:0]      srem_ff, srem_in;
   logic [VSUM_W-1:0]     vsum_ff, vsum_in;
   logic [ROOT_W-1:0]     horiz_ff, horiz_in;
   logic [DIV_W-1:0]      drem_ff, drem_in;
   logic [DIV_W-1:0]      dvsr_ff, dvsr_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [NUM_W-1:0]      quo_ff, quo_in;
   logic [RATIO_W-1:0]    ratio_r_ff, ratio_r_in;
   logic [RATIO_W-1:0]    ratio_l_ff, ratio_l_in;
   logic [RATIO_W-1:0]    rsp_ratio_r_ff, rsp_ratio_r_in;
   logic [RATIO_W-1:0]    rsp_ratio_l_ff, rsp_ratio_l_in;
   logic [RATIO_W-1:0]    rsp_mean_r_ff, rsp_mean_r_in;
   logic [RATIO_W-1:0]    rsp_mean_l_ff, rsp_mean_l_in;
   logic                  rsp_upd_ff, rsp_upd_in;
   logic                  rsp_degen_ff, rsp_degen_in;

   // helpers
   logic                  req_accept;
   logic                  idx_kept;
   logic                  idx_last;
   logic [SLOT_W-1:0]     wr_slot;
   logic [SLOT_W-1:0]     rd_addr;
   logic                  csr_write;
   logic [WIN_W-1:0]      win_eff;
   logic signed [MAG_W:0] dx, dy;
   logic [MAG_W:0]        dx_abs, dy_abs;
   logic [SQ_W-1:0]       sq_step;
   logic [REM_W+1:0]      srem_try, sroot_trial, srem_diff;
   logic                  sroot_fit;
   logic [DIV_W:0]        drem_try, drem_diff;
   logic                  drem_fit;
   logic [DIV_W-1:0]      horiz3;
   logic                  ratio_ovf;
   logic [SUM_W-1:0]      sum_r_next, sum_l_next;
   logic [WIN_W-1:0]      count_next;

   assign req_accept = req.valid && req.ready;
   assign idx_kept   = (req.landmark_index >= IDX_W'(EYE_FIRST))
                    && (req.landmark_index <= IDX_W'(EYE_LAST));
   assign idx_last   = (req.landmark_index == IDX_W'(EYE_LAST));
   assign wr_slot    = SLOT_W'(req.landmark_index - IDX_W'(EYE_FIRST));
   assign req.ready  = (state_ff == S_IDLE);

   assign rd_addr = {eye_ff, (state_ff == S_RD_B) ? point_b(dist_ff) : point_a(dist_ff)};

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_WINDOW_LEN)
                     ? CSR_DATA_W'(win_ff) : '0;

   always_comb begin
      if (win_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (win_ff > WIN_W'(WIN_MAX)) begin
         win_eff = WIN_W'(WIN_MAX);
      end else begin
         win_eff = win_ff;
      end
   end

   // coordinate differences of the point pair, x in the upper half
   assign dx = {pa_ff[POINT_W-1], pa_ff[POINT_W-1:COORD_BITS]}
             - {mem_q_ff[POINT_W-1], mem_q_ff[POINT_W-1:COORD_BITS]};
   assign dy = {pa_ff[COORD_BITS-1], pa_ff[COORD_BITS-1:0]}
             - {mem_q_ff[COORD_BITS-1], mem_q_ff[COORD_BITS-1:0]};
   assign dx_abs = dx[MAG_W] ? (~dx + 1'b1) : dx;
   assign dy_abs = dy[MAG_W] ? (~dy + 1'b1) : dy;

   // shift-add square step: one multiplier bit of each axis per cycle
   assign sq_step = sq_ff + (mpx_ff[0] ? SQ_W'(mcx_ff) : '0)
                          + (mpy_ff[0] ? SQ_W'(mcy_ff) : '0);

   // square root: one result bit per cycle
   assign srem_try    = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign sroot_trial = {2'b00, root_ff, 2'b01};
   assign sroot_fit   = (srem_try >= sroot_trial);
   assign srem_diff   = srem_try - sroot_trial;

   // restoring divide: one quotient bit per cycle
   assign drem_try  = {drem_ff, num_ff[NUM_W-1]};
   assign drem_fit  = (drem_try >= {1'b0, dvsr_ff});
   assign drem_diff = drem_try - {1'b0, dvsr_ff};

   assign horiz3    = DIV_W'(horiz_ff) + DIV_W'({horiz_ff, 1'b0});
   // quotient reaches 2^16 exactly when vsum >= 16 * (3 * horiz)
   assign ratio_ovf = ({4'b0, vsum_ff} >= {horiz3, 4'b0});

   assign sum_r_next = sum_r_ff + SUM_W'(ratio_r_ff);
   assign sum_l_next = sum_l_ff + SUM_W'(ratio_l_ff);
   assign count_next = count_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      div_ret_in     = div_ret_ff;
      eye_in         = eye_ff;
      dist_in        = dist_ff;
      cnt_in         = cnt_ff;
      degen_in       = degen_ff;
      upd_in         = upd_ff;
      sum_r_in       = sum_r_ff;
      sum_l_in       = sum_l_ff;
      count_in       = count_ff;
      held_r_in      = held_r_ff;
      held_l_in      = held_l_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      pa_in          = pa_ff;
      mcx_in         = mcx_ff;
      mcy_in         = mcy_ff;
      mpx_in         = mpx_ff;
      mpy_in         = mpy_ff;
      sq_in          = sq_ff;
      rad_in         = rad_ff;
      root_in        = root_ff;
      srem_in        = srem_ff;
      vsum_in        = vsum_ff;
      horiz_in       = horiz_ff;
      drem_in        = drem_ff;
      dvsr_in        = dvsr_ff;
      num_in         = num_ff;
      quo_in         = quo_ff;
      ratio_r_in     = ratio_r_ff;
      ratio_l_in     = ratio_l_ff;
      rsp_ratio_r_in = rsp_ratio_r_ff;
      rsp_ratio_l_in = rsp_ratio_l_ff;
      rsp_mean_r_in  = rsp_mean_r_ff;
      rsp_mean_l_in  = rsp_mean_l_ff;
      rsp_upd_in     = rsp_upd_ff;
      rsp_degen_in   = rsp_degen_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && idx_last) begin
               eye_in   = 1'b0;
               dist_in  = DIST_OUTER;
               degen_in = 1'b0;
               vsum_in  = '0;
               state_in = S_RD_A;
            end
         end
         S_RD_A: begin
            state_in = S_RD_B;
         end
         S_RD_B: begin
            pa_in    = mem_q_ff;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            mcx_in   = (2*MAG_W)'(dx_abs[MAG_W-1:0]);
            mcy_in   = (2*MAG_W)'(dy_abs[MAG_W-1:0]);
            mpx_in   = dx_abs[MAG_W-1:0];
            mpy_in   = dy_abs[MAG_W-1:0];
            sq_in    = '0;
            cnt_in   = CNT_W'(MAG_W);
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            sq_in  = sq_step;
            mcx_in = {mcx_ff[2*MAG_W-2:0], 1'b0};
            mcy_in = {mcy_ff[2*MAG_W-2:0], 1'b0};
            mpx_in = mpx_ff >> 1;
            mpy_in = mpy_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_ROOT_LOAD;
            end
         end
         S_ROOT_LOAD: begin
            rad_in   = RAD_W'({sq_ff, {(2*DIST_FRAC){1'b0}}});
            root_in  = '0;
            srem_in  = '0;
            cnt_in   = CNT_W'(ROOT_W);
            state_in = S_ROOT;
         end
         S_ROOT: begin
            rad_in = {rad_ff[RAD_W-3:0], 2'b00};
            if (sroot_fit) begin
               srem_in = srem_diff[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = srem_try[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            if (dist_ff == DIST_HORIZ) begin
               horiz_in = root_ff;
               state_in = S_RATIO_CHK;
            end else begin
               vsum_in  = vsum_ff + VSUM_W'(root_ff);
               dist_in  = dist_type'(dist_ff + 2'd1);
               state_in = S_RD_A;
            end
         end
         S_RATIO_CHK: begin
            if (horiz_ff == '0) begin
               degen_in = 1'b1;
               quo_in   = NUM_W'(RATIO_MAX);
               state_in = S_EYE_DONE;
            end else if (ratio_ovf) begin
               quo_in   = NUM_W'(RATIO_MAX);
               state_in = S_EYE_DONE;
            end else begin
               // upper numerator bits form the starting remainder
               drem_in    = vsum_ff >> DIST_FRAC;
               num_in     = {vsum_ff[DIST_FRAC-1:0], {(NUM_W-DIST_FRAC){1'b0}}};
               dvsr_in    = horiz3;
               quo_in     = '0;
               cnt_in     = CNT_W'(RATIO_W);
               div_ret_in = S_EYE_DONE;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            if (drem_fit) begin
               drem_in = drem_diff[DIV_W-1:0];
               quo_in  = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               drem_in = drem_try[DIV_W-1:0];
               quo_in  = {quo_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = div_ret_ff;
            end
         end
         S_EYE_DONE: begin
            if (eye_ff) begin
               ratio_r_in = quo_ff[RATIO_W-1:0];
               state_in   = S_MEAN_ACC;
            end else begin
               ratio_l_in = quo_ff[RATIO_W-1:0];
               eye_in     = 1'b1;
               dist_in    = DIST_OUTER;
               vsum_in    = '0;
               state_in   = S_RD_A;
            end
         end
         S_MEAN_ACC: begin
            sum_r_in = sum_r_next;
            sum_l_in = sum_l_next;
            count_in = count_next;
            upd_in   = 1'b0;
            if (count_next >= win_eff) begin
               drem_in    = '0;
               num_in     = NUM_W'(sum_r_next);
               dvsr_in    = DIV_W'(win_eff);
               quo_in     = '0;
               cnt_in     = CNT_W'(SUM_W);
               div_ret_in = S_MEAN_R_DONE;
               state_in   = S_DIV;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_MEAN_R_DONE: begin
            held_r_in  = quo_ff[RATIO_W-1:0];
            drem_in    = '0;
            num_in     = NUM_W'(sum_l_ff);
            dvsr_in    = DIV_W'(win_eff);
            quo_in     = '0;
            cnt_in     = CNT_W'(SUM_W);
            div_ret_in = S_MEAN_L_DONE;
            state_in   = S_DIV;
         end
         S_MEAN_L_DONE: begin
            held_l_in = quo_ff[RATIO_W-1:0];
            sum_r_in  = '0;
            sum_l_in  = '0;
            count_in  = '0;
            upd_in    = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_ratio_r_in = ratio_r_ff;
               rsp_ratio_l_in = ratio_l_ff;
               rsp_mean_r_in  = held_r_ff;
               rsp_mean_l_in  = held_l_ff;
               rsp_upd_in     = upd_ff;
               rsp_degen_in   = degen_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_ret_ff   <= S_EYE_DONE;
         eye_ff       <= 1'b0;
         dist_ff      <= DIST_OUTER;
         cnt_ff       <= '0;
         degen_ff     <= 1'b0;
         upd_ff       <= 1'b0;
         sum_r_ff     <= '0;
         sum_l_ff     <= '0;
         count_ff     <= '0;
         held_r_ff    <= '0;
         held_l_ff    <= '0;
         win_ff       <= WIN_W'(WIN_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_ret_ff   <= div_ret_in;
         eye_ff       <= eye_in;
         dist_ff      <= dist_in;
         cnt_ff       <= cnt_in;
         degen_ff     <= degen_in;
         upd_ff       <= upd_in;
         sum_r_ff     <= sum_r_in;
         sum_l_ff     <= sum_l_in;
         count_ff     <= count_in;
         held_r_ff    <= held_r_in;
         held_l_ff    <= held_l_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && (csr_paddr[CSR_ADDR_W-1:2] == REG_WINDOW_LEN)) begin
            win_ff <= csr_pwdata[WIN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      pa_ff          <= pa_in;
      mcx_ff         <= mcx_in;
      mcy_ff         <= mcy_in;
      mpx_ff         <= mpx_in;
      mpy_ff         <= mpy_in;
      sq_ff          <= sq_in;
      rad_ff         <= rad_in;
      root_ff        <= root_in;
      srem_ff        <= srem_in;
      vsum_ff        <= vsum_in;
      horiz_ff       <= horiz_in;
      drem_ff        <= drem_in;
      dvsr_ff        <= dvsr_in;
      num_ff         <= num_in;
      quo_ff         <= quo_in;
      ratio_r_ff     <= ratio_r_in;
      ratio_l_ff     <= ratio_l_in;
      rsp_ratio_r_ff <= rsp_ratio_r_in;
      rsp_ratio_l_ff <= rsp_ratio_l_in;
      rsp_mean_r_ff  <= rsp_mean_r_in;
      rsp_mean_l_ff  <= rsp_mean_l_in;
      rsp_upd_ff     <= rsp_upd_in;
      rsp_degen_ff   <= rsp_degen_in;
   end

   // point store: x in the upper half, y in the lower half
   always_ff @(posedge clock) begin
      if (req_accept && idx_kept) begin
         mem[wr_slot] <= {req.point_x, req.point_y};
      end
      mem_q_ff <= mem[rd_addr];
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.ratio_right    = rsp_ratio_r_ff;
   assign rsp.ratio_left     = rsp_ratio_l_ff;
   assign rsp.mean_right     = rsp_mean_r_ff;
   assign rsp.mean_left      = rsp_mean_l_ff;
   assign rsp.mean_updated   = rsp_upd_ff;
   assign rsp.degenerate_eye = rsp_degen_ff;

   a_div_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (drem_ff < dvsr_ff))
      else $error("divider remainder not below divisor");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= WIN_W'(WIN_MAX))
      else $error("sample count beyond largest window");

   a_degen_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_degen_ff) |->
         (rsp_ratio_r_ff == RATIO_MAX) || (rsp_ratio_l_ff == RATIO_MAX))
      else $error("degenerate eye without saturated ratio");

   a_block_close_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MEAN_L_DONE) |=> (count_ff == '0) && (sum_r_ff == '0))
      else $error("closed block left sums or count behind");

endmodule
`default_nettype wire

// ===== dv/tb_eye_aspect_ratio_block_mean.sv =====
// Self-checking testbench for the eye aspect ratio block with per-eye block means.
`timescale 1ns / 1ps
module tb_eye_aspect_ratio_block_mean;
   import earbm_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [IDX_W-1:0] index_type;
   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [RATIO_W-1:0] ratio_right;
      logic [RATIO_W-1:0] ratio_left;
      logic [RATIO_W-1:0] mean_right;
      logic [RATIO_W-1:0] mean_left;
      logic               mean_updated;
      logic               degenerate_eye;
   } eye_result_type;

   typedef enum int {FACE_FULL, FACE_SHORT, FACE_WALK} face_kind_type;

   localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
   localparam logic [CSR_ADDR_W-1:0] WIN_ADDR = {REG_WINDOW_LEN, 2'b00};
   localparam int SETTLE_CYCLES = 400;
   localparam int CYCLE_LIMIT = 600_000;
   localparam int ITEM_TARGET = 700;
   localparam int MAX_PRINTS = 40;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   earbm_req_if req_ch ();
   earbm_rsp_if rsp_ch ();

   eye_aspect_ratio_block_mean uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   point_type           eye_store [EYE_SLOTS];
   logic [SUM_W-1:0]    sum_right_acc, sum_left_acc;
   logic [WIN_W-1:0]    face_count;
   logic [RATIO_W-1:0]  held_right, held_left;
   logic [WIN_W-1:0]    window_len_model;
   eye_result_type      pending_ratios [$];

   // scoreboard and flow control
   int        error_count = 0;
   int        items_sent = 0;
   int        results_seen = 0;
   int        means_closed = 0;
   int        degenerate_faces = 0;
   int        cycle_count = 0;
   bit        steady = 0;
   bit        rsp_taken = 0;
   int        stall_request = 0;
   point_type face_pts [EYE_SLOTS];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_ratios.size());
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input u64_type got, input u64_type want);
      if (error_count < MAX_PRINTS)
         $display("tb: mismatch %s: got %0d, want %0d (result %0d, t=%0t)",
                  what, got, want, results_seen, $realtime);
      error_count++;
   endtask

   // ---------------- predictor ----------------

   function automatic u64_type floor_root(input u64_type v);
      u64_type r, b;
      r = 0;
      b = u64_type'(1) << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // distance between two stored points, 4 fractional bits
   function automatic u64_type slot_distance(input int sa, input int sb);
      longint dx, dy;
      u64_type sq;
      dx = longint'($signed(eye_store[sa][POINT_W-1:COORD_BITS]))
         - longint'($signed(eye_store[sb][POINT_W-1:COORD_BITS]));
      dy = longint'($signed(eye_store[sa][COORD_BITS-1:0]))
         - longint'($signed(eye_store[sb][COORD_BITS-1:0]));
      sq = dx * dx + dy * dy;
      return floor_root(sq << (2 * DIST_FRAC));
   endfunction

   function automatic logic [RATIO_W-1:0] eye_ratio(input int base, output logic flat);
      u64_type v, h, q;
      v = slot_distance(base + 1, base + 7) + slot_distance(base + 3, base + 5)
        + slot_distance(base + 2, base + 6);
      h = slot_distance(base, base + 4);
      flat = 1'b0;
      if (h == 0) begin
         flat = 1'b1;
         return RATIO_MAX;
      end
      q = (v << RATIO_FRAC) / (3 * h);
      return (q > RATIO_MAX) ? RATIO_MAX : q[RATIO_W-1:0];
   endfunction

   task automatic predict_eye_ratios(input coord_type x, input coord_type y,
                                     input index_type idx);
      eye_result_type r;
      logic flat_l, flat_r;
      int eff;
      if (idx < EYE_FIRST || idx > EYE_LAST) return;
      eye_store[idx - EYE_FIRST] = {x, y};
      if (idx != EYE_LAST) return;
      r.ratio_left  = eye_ratio(0, flat_l);
      r.ratio_right = eye_ratio(POINTS_PER_EYE, flat_r);
      r.degenerate_eye = flat_l | flat_r;
      if (r.degenerate_eye) degenerate_faces++;
      eff = window_len_model;
      if (eff == 0) eff = 1;
      if (eff > WIN_MAX) eff = WIN_MAX;
      sum_right_acc = sum_right_acc + r.ratio_right;
      sum_left_acc  = sum_left_acc + r.ratio_left;
      face_count    = face_count + 1'b1;
      r.mean_updated = 1'b0;
      if (face_count >= eff) begin
         held_right = RATIO_W'(sum_right_acc / eff);
         held_left  = RATIO_W'(sum_left_acc / eff);
         sum_right_acc = '0;
         sum_left_acc  = '0;
         face_count    = '0;
         r.mean_updated = 1'b1;
         means_closed++;
      end
      r.mean_right = held_right;
      r.mean_left  = held_left;
      pending_ratios.push_back(r);
   endtask

   // ---------------- result checking ----------------

   always @(posedge clock) begin : check_results
      eye_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_taken = 1'b1;
         results_seen++;
         if (pending_ratios.size() == 0) begin
            report_mismatch("unexpected result, ratio_left", rsp_ch.ratio_left, 0);
         end else begin
            want = pending_ratios.pop_front();
            if (rsp_ch.ratio_right !== want.ratio_right)
               report_mismatch("ratio_right", rsp_ch.ratio_right, want.ratio_right);
            if (rsp_ch.ratio_left !== want.ratio_left)
               report_mismatch("ratio_left", rsp_ch.ratio_left, want.ratio_left);
            if (rsp_ch.mean_right !== want.mean_right)
               report_mismatch("mean_right", rsp_ch.mean_right, want.mean_right);
            if (rsp_ch.mean_left !== want.mean_left)
               report_mismatch("mean_left", rsp_ch.mean_left, want.mean_left);
            if (rsp_ch.mean_updated !== want.mean_updated)
               report_mismatch("mean_updated", rsp_ch.mean_updated, want.mean_updated);
            if (rsp_ch.degenerate_eye !== want.degenerate_eye)
               report_mismatch("degenerate_eye", rsp_ch.degenerate_eye, want.degenerate_eye);
         end
      end
   end

   // result receiver: random gap per transaction, plus long holds on request
   initial begin : result_receiver
      int sink_gap;
      int stall_left;
      sink_gap = 0;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            if (stall_request != 0) begin
               stall_left = stall_request;
               stall_request = 0;
            end
            if (rsp_taken) begin
               rsp_taken = 1'b0;
               sink_gap = steady ? 0 : $urandom_range(0, 9);
            end
            if (stall_left != 0) begin
               stall_left--;
               rsp_ch.ready <= 1'b0;
            end else if (sink_gap != 0) begin
               sink_gap--;
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_point(input coord_type x, input coord_type y, input index_type idx);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid          <= 1'b1;
      req_ch.point_x        <= x;
      req_ch.point_y        <= y;
      req_ch.landmark_index <= idx;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      predict_eye_ratios(x, y, idx);
   endtask

   // drop valid, drain every outstanding result, then let the datapath settle
   task automatic wait_for_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_ratios.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic read_window_len();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= WIN_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[WIN_W-1:0] !== window_len_model)
         report_mismatch("window_len read-back", csr_prdata[WIN_W-1:0], window_len_model);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_window_len(input int value);
      wait_for_idle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WIN_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      window_len_model = WIN_W'(value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      read_window_len();
   endtask

   function automatic coord_type clamp_coord(input int v);
      if (v < COORD_MIN) v = COORD_MIN;
      if (v > COORD_MAX) v = COORD_MAX;
      return coord_type'(v);
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 3))
         0: return coord_type'($urandom);
         1: return $urandom_range(0, 1) ? coord_type'(COORD_MIN) : coord_type'(COORD_MAX);
         default: return clamp_coord(int'($urandom_range(0, 80)) - 40);
      endcase
   endfunction

   // one face's eye points clustered around a random center; sometimes flat or wild
   task automatic make_face();
      int cx, cy, spread;
      for (int e = 0; e < 2; e++) begin
         cx = int'($urandom_range(0, 8191)) + COORD_MIN;
         cy = int'($urandom_range(0, 8191)) + COORD_MIN;
         spread = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 60);
         for (int k = 0; k < POINTS_PER_EYE; k++) begin
            if ($urandom_range(0, 11) == 0)
               face_pts[e * POINTS_PER_EYE + k] = {rand_coord(), rand_coord()};
            else
               face_pts[e * POINTS_PER_EYE + k] = {
                  clamp_coord(cx + int'($urandom_range(0, 2 * spread)) - spread),
                  clamp_coord(cy + int'($urandom_range(0, 2 * spread)) - spread)};
         end
         // zero horizontal distance
         if ($urandom_range(0, 7) == 0)
            face_pts[e * POINTS_PER_EYE + 4] = face_pts[e * POINTS_PER_EYE];
      end
   endtask

   task automatic send_slot(input int slot);
      send_point(face_pts[slot][POINT_W-1:COORD_BITS], face_pts[slot][COORD_BITS-1:0],
                 index_type'(EYE_FIRST + slot));
   endtask

   task automatic send_noise();
      index_type idx;
      idx = index_type'($urandom_range(0, 127));
      while (idx >= EYE_FIRST && idx <= EYE_LAST) idx = index_type'($urandom_range(0, 127));
      send_point(rand_coord(), rand_coord(), idx);
   endtask

   task automatic send_face(input face_kind_type kind);
      int order [EYE_SLOTS];
      int a, b, tmp, n;
      make_face();
      case (kind)
         FACE_FULL: begin
            for (int k = 0; k < EYE_SLOTS; k++) order[k] = k;
            // now and then a broken sequence: two points swapped, or one dropped
            if ($urandom_range(0, 9) == 0) begin
               a = $urandom_range(0, EYE_SLOTS - 2);
               b = $urandom_range(0, EYE_SLOTS - 2);
               tmp = order[a]; order[a] = order[b]; order[b] = tmp;
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, EYE_SLOTS - 2) : -1;
            for (int k = 0; k < EYE_SLOTS; k++)
               if (k != n) send_slot(order[k]);
         end
         FACE_SHORT: begin
            n = $urandom_range(0, 3);
            repeat (n) send_slot($urandom_range(0, EYE_SLOTS - 2));
            if ($urandom_range(0, 3) == 0) send_noise();
            send_slot(EYE_SLOTS - 1);
         end
         default: begin
            // ascending walk through the face, other landmarks sprinkled in
            for (int i = 0; i < 98; i++) begin
               if (i >= EYE_FIRST && i <= EYE_LAST)
                  send_slot(i - EYE_FIRST);
               else if ($urandom_range(0, 7) == 0)
                  send_point(rand_coord(), rand_coord(), index_type'(i));
            end
            if ($urandom_range(0, 3) == 0)
               send_point(rand_coord(), rand_coord(), index_type'($urandom_range(98, 127)));
         end
      endcase
   endtask

   // ---------------- tests ----------------

   task automatic test_register_reset();
      read_window_len();
   endtask

   task automatic test_directed_landmarks();
      int xs [EYE_SLOTS] = '{-4096, -2000, 0, 2000, 4095, 2000, 0, -2000,
                             100, 90, 100, 110, 100, 110, 100, 90};
      int ys [EYE_SLOTS] = '{-4096, -4096, -4096, -4096, 4095, 4095, 4095, 4095,
                             -7, -20, -20, -20, -7, 5, 5, 5};
      index_type noise [5] = '{index_type'(0), index_type'(EYE_FIRST - 1),
                               index_type'(EYE_LAST + 1), index_type'(97),
                               index_type'(127)};
      // full face: widest left eye, right eye with zero horizontal distance
      for (int k = 0; k < EYE_SLOTS; k++)
         send_point(coord_type'(xs[k]), coord_type'(ys[k]), index_type'(EYE_FIRST + k));
      foreach (noise[i]) send_point(rand_coord(), rand_coord(), noise[i]);
      // left horizontal shrinks to one pixel: ratio saturates
      send_point(coord_type'(-4095), coord_type'(-4096), index_type'(EYE_FIRST + 4));
      send_point(coord_type'(xs[15]), coord_type'(ys[15]), index_type'(EYE_LAST));
      // right eye recovers: saturation alone, flag low
      send_point(coord_type'(130), coord_type'(-7), index_type'(EYE_FIRST + 12));
      send_point(coord_type'(90), coord_type'(6), index_type'(EYE_LAST));
   endtask

   task automatic test_window_lengths();
      write_window_len(1);
      repeat (6) send_face(FACE_FULL);
      write_window_len(WIN_MAX);
      steady = 1;
      repeat (20) send_face(FACE_SHORT);
      steady = 0;
      repeat (WIN_MAX - 18) send_face(FACE_SHORT);
      write_window_len(0);
      repeat (4) send_face(FACE_SHORT);
      write_window_len(127);
      repeat (5) send_face(FACE_SHORT);
      // shorter than the open block: closes on the next face
      write_window_len(3);
      repeat (2) send_face(FACE_SHORT);
   endtask

   task automatic test_backpressure();
      write_window_len(5);
      stall_request = 1500;
      repeat (4) send_face(FACE_FULL);
      wait_for_idle();
   endtask

   task automatic test_random_faces();
      int faces;
      faces = 0;
      while (items_sent < ITEM_TARGET) begin
         if (faces % 6 == 0) write_window_len($urandom_range(2, 12));
         if ($urandom_range(0, 2) == 0) send_face(FACE_FULL);
         else send_face(FACE_WALK);
         faces++;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.landmark_index = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sum_right_acc = '0;
      sum_left_acc = '0;
      face_count = '0;
      held_right = '0;
      held_left = '0;
      window_len_model = WIN_W'(WIN_RESET);
      foreach (eye_store[i]) eye_store[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_reset();
      test_directed_landmarks();
      test_window_lengths();
      test_backpressure();
      test_random_faces();
      wait_for_idle();

      $display("tb: %0d landmark transactions, %0d eye results, %0d block means closed",
               items_sent, results_seen, means_closed);
      $display("tb: %0d faces with a flat eye; window lengths 0, 1, 64, 127 and mid-block cut",
               degenerate_faces);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
